// File: hdl/mbrf_pkg.sv
// Shared types, constants and helpers for the Modbus ASCII request framer.
package mbrf_pkg;

    // Binary content of one frame, in transmit order (station sent first).
    typedef struct packed {
        logic [7:0] station;
        logic [7:0] func;
        logic [7:0] reg_hi;
        logic [7:0] reg_lo;
        logic [7:0] data_hi;
        logic [7:0] data_lo;
        logic [7:0] lrc;
    } mbrf_frame_t;

    localparam int FRAME_BITS  = $bits(mbrf_frame_t);
    localparam int FRAME_LEN   = 17;
    localparam int POS_W       = 5;
    localparam int NIB_W       = 4;

    localparam logic [POS_W-1:0] POS_COLON = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CR    = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_LF    = POS_W'(FRAME_LEN - 1);

    localparam logic       ACTION_WRITE = 1'b1;
    localparam logic [7:0] FUNC_READ    = 8'h03;
    localparam logic [7:0] FUNC_WRITE   = 8'h06;
    localparam logic [15:0] READ_COUNT  = 16'h0001;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;

    // Uppercase ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CHAR_ZERO + {4'd0, nib};
        end else begin
            r = CHAR_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: hdl/modbus_ascii_request_framer.sv
// Modbus ASCII request framer top level: front end, frame queue and byte sequencer.
//
// Each accepted request (read holding register, function 03, or write single
// register, function 06) produces one 17-byte Modbus ASCII frame on the m_
// channel: ':' then uppercase hex of station (unit_index + 1, wrapping to 00
// at 255), function, register address, data (0001 for a read, write_value
// for a write), the LRC as two hex characters, then CR and LF; m_frame_end
// marks the LF. Output runs at one byte per cycle while m_ready is high, the
// byte sequencer emitting one character per cycle. The front end builds the
// binary bytes and LRC combinationally into its output register and takes a
// new request every cycle while the frame queue (QUEUE_DEPTH frames) has
// room, so requests are absorbed while an earlier frame is still being sent.
// On an empty path a request passes the front-end register and the frame
// queue before its ':' byte is loaded into the output register. Reset is
// synchronous, active low; no other initialization is needed.
module modbus_ascii_request_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_unit_index,
    input  logic [15:0] s_register_address,
    input  logic [15:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_char,
    output logic        m_frame_end
);
    import mbrf_pkg::*;

    // front end -> queue
    logic        f_valid, f_ready;
    mbrf_frame_t f_frame;
    // queue -> byte sequencer
    logic        q_valid, q_pop;
    mbrf_frame_t q_frame;

    mbrf_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_unit_index       (s_unit_index),
        .s_register_address (s_register_address),
        .s_write_value      (s_write_value),
        .f_valid            (f_valid),
        .f_ready            (f_ready),
        .f_frame            (f_frame)
    );

    // Holds built frames so the front end keeps accepting during a frame.
    mbrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_frame  (f_frame),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_frame (q_frame)
    );

    // Head frame stays in the queue until its LF byte is loaded.
    mbrf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_frame      (q_frame),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_char (m_frame_char),
        .m_frame_end  (m_frame_end)
    );

endmodule

// File: hdl/mbrf_front.sv
// Request front end: builds the binary frame bytes and the LRC, one request per cycle while the queue has room.
module mbrf_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [7:0]           s_unit_index,
    input  logic [15:0]          s_register_address,
    input  logic [15:0]          s_write_value,
    output logic                 f_valid,
    input  logic                 f_ready,
    output mbrf_pkg::mbrf_frame_t f_frame
);
    import mbrf_pkg::*;

    logic        f_valid_reg, f_valid_next;
    mbrf_frame_t f_frame_reg, f_frame_next;
    logic [15:0] data;
    logic [7:0]  sum;

    assign s_ready = !f_valid_reg || f_ready;
    assign f_valid = f_valid_reg;
    assign f_frame = f_frame_reg;

    always_comb begin
        data = (s_action == ACTION_WRITE) ? s_write_value : READ_COUNT;
        f_frame_next.station = s_unit_index + 8'd1;  // wraps at 255
        f_frame_next.func    = (s_action == ACTION_WRITE) ? FUNC_WRITE : FUNC_READ;
        f_frame_next.reg_hi  = s_register_address[15:8];
        f_frame_next.reg_lo  = s_register_address[7:0];
        f_frame_next.data_hi = data[15:8];
        f_frame_next.data_lo = data[7:0];
        sum = f_frame_next.station + f_frame_next.func + f_frame_next.reg_hi
            + f_frame_next.reg_lo + f_frame_next.data_hi + f_frame_next.data_lo;
        f_frame_next.lrc = 8'd0 - sum;
        if (s_valid && s_ready) begin
            f_valid_next = 1'b1;
        end else if (f_ready) begin
            f_valid_next = 1'b0;
        end else begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (s_valid && s_ready) begin
            f_frame_reg <= f_frame_next;
        end
    end

endmodule

// File: hdl/mbrf_queue.sv
// Small FIFO of built frames between the front end and the byte sequencer.
module mbrf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mbrf_pkg::mbrf_frame_t in_frame,
    output logic                  out_valid,
    input  logic                  out_pop,
    output mbrf_pkg::mbrf_frame_t out_frame
);
    import mbrf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mbrf_frame_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_frame = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_frame;
        end
    end

endmodule

// File: hdl/mbrf_back.sv
// Byte sequencer: walks the 17 frame positions and drives the registered output.
module mbrf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  mbrf_pkg::mbrf_frame_t q_frame,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_frame_char,
    output logic                  m_frame_end
);
    import mbrf_pkg::*;

    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            char_reg, char_next;
    logic                  end_reg, end_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  load, take, last;
    logic [POS_W-1:0]      pos_m1;
    logic [NIB_W-1:0]      nib_idx;
    logic [FRAME_BITS-1:0] shifted;

    assign m_valid      = m_valid_reg;
    assign m_frame_char = char_reg;
    assign m_frame_end  = end_reg;

    assign load  = !m_valid_reg || m_ready;
    assign take  = load && q_valid;
    assign last  = (pos_reg == POS_LF);
    assign q_pop = take && last;

    always_comb begin
        // hex positions 1..14 map to nibbles 0..13 of the frame record
        pos_m1  = pos_reg - POS_W'(1);
        nib_idx = pos_m1[NIB_W-1:0];
        shifted = q_frame << {nib_idx, 2'b00};

        if (pos_reg == POS_COLON) begin
            char_next = CHAR_COLON;
        end else if (pos_reg == POS_CR) begin
            char_next = CHAR_CR;
        end else if (last) begin
            char_next = CHAR_LF;
        end else begin
            char_next = hex_char(shifted[FRAME_BITS-1 -: 4]);
        end
        end_next = last;

        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
            pos_next     = last ? '0 : pos_reg + POS_W'(1);
        end else if (load) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            pos_reg     <= pos_next;
        end
        if (take) begin
            char_reg <= char_next;
            end_reg  <= end_next;
        end
    end

endmodule

// File: sim/tb_modbus_ascii_request_framer.sv
// Self-checking testbench for the Modbus ASCII request framer: random requests, byte-level frame checks.
module tb_modbus_ascii_request_framer;

    import mbrf_pkg::*;

    // Expected-frame store: every accepted request becomes 17 expected bytes,
    // and each byte the framer hands over is compared with the oldest one.
    class FrameScoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } frame_byte_t;

        frame_byte_t pending_bytes[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [7:0] hex_ascii(logic [3:0] nib);
            string digits;
            digits = "0123456789ABCDEF";
            return digits[nib];
        endfunction

        function void push_byte(logic [7:0] ch, logic last);
            frame_byte_t b;
            b.ch   = ch;
            b.last = last;
            pending_bytes.push_back(b);
        endfunction

        function void push_hex(logic [7:0] value);
            push_byte(hex_ascii(value[7:4]), 1'b0);
            push_byte(hex_ascii(value[3:0]), 1'b0);
        endfunction

        // Builds the frame the framer must send for one accepted request.
        function void note_request(logic action, logic [7:0] unit, logic [15:0] reg_addr,
                                   logic [15:0] wval);
            logic [7:0]  body [6];
            logic [7:0]  byte_sum;
            logic [15:0] data_word;
            data_word = (action == ACTION_WRITE) ? wval : READ_COUNT;
            body[0] = unit + 8'd1;            // station wraps to 00 for index 255
            body[1] = (action == ACTION_WRITE) ? FUNC_WRITE : FUNC_READ;
            body[2] = reg_addr[15:8];
            body[3] = reg_addr[7:0];
            body[4] = data_word[15:8];
            body[5] = data_word[7:0];
            byte_sum = 8'd0;
            foreach (body[i]) byte_sum = byte_sum + body[i];
            push_byte(CHAR_COLON, 1'b0);
            foreach (body[i]) push_hex(body[i]);
            push_hex(8'd0 - byte_sum);        // LRC: two's complement of the sum
            push_byte(CHAR_CR, 1'b0);
            push_byte(CHAR_LF, 1'b1);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void check_byte(logic [7:0] ch, logic last);
            frame_byte_t want;
            if (pending_bytes.size() == 0) begin
                flag($sformatf("unexpected byte 0x%02h end=%b", ch, last));
                return;
            end
            want = pending_bytes.pop_front();
            if (ch !== want.ch)
                flag($sformatf("frame_char expected 0x%02h actual 0x%02h", want.ch, ch));
            if (last !== want.last)
                flag($sformatf("frame_end expected %b actual %b (char 0x%02h)",
                               want.last, last, want.ch));
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_action;
    logic [7:0]  s_unit_index;
    logic [15:0] s_register_address;
    logic [15:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_char;
    logic        m_frame_end;

    FrameScoreboard frame_sb;
    bit             sender_calm;
    bit             receiver_calm;
    bit             rx_enable;

    modbus_ascii_request_framer i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_unit_index       (s_unit_index),
        .s_register_address (s_register_address),
        .s_write_value      (s_write_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_char       (m_frame_char),
        .m_frame_end        (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop: even the slowest legal run (every byte stalled and every request
    // gapped by the longest drawn wait) ends before this stop.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Per-transaction wait: random, or none at all while in a calm stretch.
    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Presents one request. Entered and left at a falling edge; s_valid is
    // dropped only when a gap is drawn, so back-to-back requests keep it high.
    task automatic send_request(logic action, logic [7:0] unit, logic [15:0] reg_addr,
                                logic [15:0] wval);
        int gap;
        if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_action           <= action;
        s_unit_index       <= unit;
        s_register_address <= reg_addr;
        s_write_value      <= wval;
        do @(posedge aclk); while (s_ready !== 1'b1);
        frame_sb.note_request(action, unit, reg_addr, wval);
        @(negedge aclk);
    endtask

    // Holds off the sender until every frame already requested is fully out.
    task automatic drain_frames();
        s_valid <= 1'b0;
        do @(negedge aclk); while (frame_sb.outstanding() != 0);
    endtask

    // Result side: draw a stall per byte, then take the byte and check it.
    initial begin
        m_ready = 1'b0;
        wait (rx_enable);
        @(negedge aclk);
        forever begin
            int stall;
            if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
            stall = draw_wait(receiver_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            frame_sb.check_byte(m_frame_char, m_frame_end);
            @(negedge aclk);
        end
    end

    initial begin
        logic        action;
        logic [7:0]  unit;
        logic [15:0] reg_addr;
        logic [15:0] wval;
        int          errors;

        frame_sb           = new();
        sender_calm        = 1'b0;
        receiver_calm      = 1'b0;
        rx_enable          = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_action           = 1'b0;
        s_unit_index       = 8'd0;
        s_register_address = 16'd0;
        s_write_value      = 16'd0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn   <= 1'b1;
        rx_enable = 1'b1;
        @(negedge aclk);

        // Directed: both functions, field extremes, station wrap, negative
        // write data, read ignoring write_value, and an LRC of zero.
        send_request(1'b0, 8'd0,   16'h0000, 16'h0000);
        send_request(1'b1, 8'd0,   16'h0000, 16'h0000);
        send_request(1'b0, 8'd246, 16'hFFFF, 16'hFFFF);
        send_request(1'b1, 8'd246, 16'hFFFF, 16'hFFFF);
        send_request(1'b0, 8'd255, 16'h1234, 16'h0000);  // station wraps to 00
        send_request(1'b1, 8'd255, 16'hFFFF, 16'hFFFF);
        send_request(1'b1, 8'd254, 16'h00FF, 16'h8000);  // most negative value
        send_request(1'b1, 8'd9,   16'hABCD, 16'hFFFE);  // -2
        send_request(1'b1, 8'd15,  16'h8000, 16'h7FFF);
        send_request(1'b0, 8'd1,   16'h0100, 16'hDEAD);  // read: data stays 0001
        send_request(1'b0, 8'd0,   16'h00FB, 16'h5A5A);  // byte sum 0x100, LRC 00
        send_request(1'b1, 8'd127, 16'h5555, 16'hAAAA);
        send_request(1'b1, 8'd128, 16'hAAAA, 16'h5555);
        send_request(1'b0, 8'd170, 16'hFEDC, 16'h0000);
        send_request(1'b1, 8'd85,  16'h0F0F, 16'hF0F0);
        send_request(1'b1, 8'd247, 16'h0001, 16'h0001);
        send_request(1'b0, 8'd200, 16'hC0DE, 16'hFFFF);
        send_request(1'b1, 8'd31,  16'h7FFF, 16'h0001);
        drain_frames();

        // Random: mostly valid unit indexes, some beyond the documented range.
        for (int n = 0; n < 312; n++) begin
            action   = 1'($urandom_range(0, 1));
            unit     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(247, 255))
                                                   : 8'($urandom_range(0, 246));
            reg_addr = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       wval = 16'hFFFF;
                1:       wval = 16'h8000;
                2:       wval = 16'h0000;
                default: wval = 16'($urandom);
            endcase
            send_request(action, unit, reg_addr, wval);
            if (n == 150) drain_frames();
        end
        s_valid <= 1'b0;

        while (frame_sb.outstanding() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        errors = frame_sb.mismatches + frame_sb.outstanding();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mbrf_pkg.sv
hdl/mbrf_front.sv
hdl/mbrf_queue.sv
hdl/mbrf_back.sv
hdl/modbus_ascii_request_framer.sv
sim/tb_modbus_ascii_request_framer.sv
